// ===== src/mch_pkg.sv =====
`default_nettype none
package mch_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int CORDIC_ITER_DEF = 16;
  localparam int HEADING_BITS    = 16;
  localparam int THRESH_BITS     = 15;
  localparam int FRAC_BITS       = 16;
  localparam int SCALE_BITS      = 19;
  localparam int RANGE_BITS      = SAMPLE_BITS + 1;
  localparam int SUM_BITS        = SAMPLE_BITS + 3;
  localparam int DIVISOR_BITS    = SAMPLE_BITS + 3;
  localparam int DIVIDEND_BITS   = SUM_BITS + FRAC_BITS;
  localparam int DELTA_BITS      = SAMPLE_BITS + 3;
  localparam int PROD_BITS       = DELTA_BITS + SCALE_BITS;
  localparam int VEC_BITS        = PROD_BITS + 2;
  localparam int ANGLE_BITS      = 33;
  localparam int MAX_ITER        = 24;
  localparam int HEADING_LIMIT   = 23040;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(640);
  localparam logic [SCALE_BITS-1:0]  SCALE_ONE    = SCALE_BITS'(65536);
  localparam logic [SCALE_BITS-1:0]  SCALE_MAX    = SCALE_BITS'(8 * 65536 - 1);
  localparam logic signed [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(754974720);

  typedef struct packed {
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] mag_x;
    logic signed [SAMPLE_BITS-1:0] mag_y;
    logic signed [SAMPLE_BITS-1:0] mag_z;
  } mch_in_t;

  typedef struct packed {
    logic                           car;
    logic signed [HEADING_BITS-1:0] heading;
    logic                           headings_close;
    logic                           range_degenerate;
  } mch_out_t;

  function automatic logic signed [ANGLE_BITS-1:0] atan_step(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd377487360;
      5'd1:  v = 32'd222843801;
      5'd2:  v = 32'd117744544;
      5'd3:  v = 32'd59768969;
      5'd4:  v = 32'd30000467;
      5'd5:  v = 32'd15014858;
      5'd6:  v = 32'd7509261;
      5'd7:  v = 32'd3754860;
      5'd8:  v = 32'd1877459;
      5'd9:  v = 32'd938733;
      5'd10: v = 32'd469367;
      5'd11: v = 32'd234683;
      5'd12: v = 32'd117342;
      5'd13: v = 32'd58671;
      5'd14: v = 32'd29335;
      5'd15: v = 32'd14668;
      5'd16: v = 32'd7334;
      5'd17: v = 32'd3667;
      5'd18: v = 32'd1833;
      5'd19: v = 32'd917;
      5'd20: v = 32'd458;
      5'd21: v = 32'd229;
      5'd22: v = 32'd115;
      5'd23: v = 32'd57;
      default: v = 32'd0;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage
`default_nettype wire

// ===== src/magnetometer_calibrated_heading_top.sv =====
// Each sample passes through two serial divisions and two serial multiplications, one
// of each per axis, then the CORDIC loop and its rounding step; a zero corrected
// vector skips the loop and the rounding step.
// A new sample is taken only once the previous result has been loaded into the output
// register; a result left waiting holds the next one back. Synchronous active-low reset
// restores tables and threshold.
`default_nettype none
module magnetometer_calibrated_heading_top #(
  parameter int CORDIC_ITERATIONS = mch_pkg::CORDIC_ITER_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire mch_pkg::mch_in_t                   in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output mch_pkg::mch_out_t                       out_data,
  input  wire logic                               cfg_we,
  input  wire logic [mch_pkg::THRESH_BITS-1:0]    cfg_wdata
);
  import mch_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_UPD, S_RNG, S_DIV, S_MUL, S_CORD, S_FIN} state_t;

  state_t                          state_r;
  logic                            car_r, axis_r, degen_r;
  logic signed [SAMPLE_BITS-1:0]   smp_r [3];
  logic signed [SAMPLE_BITS-1:0]   amin_r [2][3];
  logic signed [SAMPLE_BITS-1:0]   amax_r [2][3];
  logic signed [HEADING_BITS-1:0]  last_r [2];
  logic [THRESH_BITS-1:0]          thresh_r;
  logic [RANGE_BITS-1:0]           rx_r, ry_r;
  logic [SUM_BITS-1:0]             sum_r;
  logic signed [DELTA_BITS-1:0]    dx_r, dy_r;
  logic [SCALE_BITS-1:0]           scale_r;
  logic signed [PROD_BITS-1:0]     cx_r;
  logic                            div_go_r, mul_go_r, cor_go_r;

  logic [RANGE_BITS-1:0]           rng [3];
  logic signed [DELTA_BITS-1:0]    dlt [2];
  logic [RANGE_BITS-1:0]           r_sel;
  logic [DIVISOR_BITS-1:0]         divisor;
  logic                            div_done, mul_done, cor_done;
  logic [DIVIDEND_BITS-1:0]        quot;
  logic signed [PROD_BITS-1:0]     prod;
  logic signed [HEADING_BITS-1:0]  hdg, h0, h1;
  logic signed [HEADING_BITS:0]    hdiff;
  logic [HEADING_BITS:0]           habs;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rng[a] = RANGE_BITS'(amax_r[car_r][a]) - RANGE_BITS'(amin_r[car_r][a]);
    end
    for (int a = 0; a < 2; a++) begin
      dlt[a] = (DELTA_BITS'(smp_r[a]) <<< 1) - DELTA_BITS'(amax_r[car_r][a])
               - DELTA_BITS'(amin_r[car_r][a]);
    end
  end

  assign r_sel   = axis_r ? ry_r : rx_r;
  assign divisor = (DIVISOR_BITS'(r_sel) <<< 1) + DIVISOR_BITS'(r_sel);

  mch_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend ({sum_r, FRAC_BITS'(0)}),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quot)
  );

  mch_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_go_r),
    .mult_a  (axis_r ? dy_r : dx_r),
    .mult_b  (scale_r),
    .done    (mul_done),
    .product (prod)
  );

  mch_cordic #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_go_r),
    .vec_x   (cx_r),
    .vec_y   (prod),
    .done    (cor_done),
    .heading (hdg)
  );

  // The new heading takes the place of this car's previous one in the comparison.
  assign h0    = car_r ? last_r[0] : hdg;
  assign h1    = car_r ? hdg : last_r[1];
  assign hdiff = (HEADING_BITS+1)'(h0) - (HEADING_BITS+1)'(h1);
  assign habs  = hdiff[HEADING_BITS] ? -hdiff : hdiff;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      div_go_r  <= 1'b0;
      mul_go_r  <= 1'b0;
      cor_go_r  <= 1'b0;
      axis_r    <= 1'b0;
      thresh_r  <= THRESH_RESET;
      for (int c = 0; c < 2; c++) begin
        last_r[c] <= '0;
        for (int a = 0; a < 3; a++) begin
          amin_r[c][a] <= SAMPLE_BITS'(100);
          amax_r[c][a] <= '0;
        end
      end
    end else begin
      div_go_r <= 1'b0;
      mul_go_r <= 1'b0;
      cor_go_r <= 1'b0;
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      // In the final state the output register is reloaded instead.
      if (out_valid && out_ready && state_r != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            car_r    <= in_data.func;
            smp_r[0] <= in_data.mag_x;
            smp_r[1] <= in_data.mag_y;
            smp_r[2] <= in_data.mag_z;
            state_r  <= S_UPD;
          end
        end
        S_UPD: begin
          for (int a = 0; a < 3; a++) begin
            if (smp_r[a] < amin_r[car_r][a]) amin_r[car_r][a] <= smp_r[a];
            if (smp_r[a] > amax_r[car_r][a]) amax_r[car_r][a] <= smp_r[a];
          end
          state_r <= S_RNG;
        end
        S_RNG: begin
          rx_r     <= rng[0];
          ry_r     <= rng[1];
          sum_r    <= SUM_BITS'(rng[0]) + SUM_BITS'(rng[1]) + SUM_BITS'(rng[2]);
          dx_r     <= dlt[0];
          dy_r     <= dlt[1];
          degen_r  <= (rng[0] == '0) || (rng[1] == '0);
          axis_r   <= 1'b0;
          div_go_r <= 1'b1;
          state_r  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            priority if (r_sel == '0) begin
              scale_r <= SCALE_ONE;
            end else if (quot > DIVIDEND_BITS'(SCALE_MAX)) begin
              scale_r <= SCALE_MAX;
            end else begin
              scale_r <= quot[SCALE_BITS-1:0];
            end
            mul_go_r <= 1'b1;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            if (!axis_r) begin
              cx_r     <= prod;
              axis_r   <= 1'b1;
              div_go_r <= 1'b1;
              state_r  <= S_DIV;
            end else begin
              cor_go_r <= 1'b1;
              state_r  <= S_CORD;
            end
          end
        end
        S_CORD: begin
          if (cor_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            last_r[car_r]             <= hdg;
            out_valid                 <= 1'b1;
            out_data.car              <= car_r;
            out_data.heading          <= hdg;
            out_data.headings_close   <= (habs <= (HEADING_BITS+1)'(thresh_r));
            out_data.range_degenerate <= degen_r;
            state_r                   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/mch_div.sv =====
`default_nettype none
module mch_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [mch_pkg::DIVIDEND_BITS-1:0]    dividend,
  input  wire logic [mch_pkg::DIVISOR_BITS-1:0]     divisor,
  output logic                                      done,
  output logic [mch_pkg::DIVIDEND_BITS-1:0]         quotient
);
  import mch_pkg::*;

  localparam int CW = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] num_r;
  logic [DIVISOR_BITS:0]    rem_r;
  logic [DIVISOR_BITS-1:0]  den_r;
  logic [CW-1:0]            cnt_r;
  logic                     busy_r;
  logic [DIVISOR_BITS+1:0]  trial;
  logic [DIVISOR_BITS+1:0]  diff;

  // One quotient bit per cycle, most significant first.
  assign trial = {rem_r, num_r[DIVIDEND_BITS-1]};
  assign diff  = trial - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        num_r    <= dividend;
        den_r    <= divisor;
        rem_r    <= '0;
        quotient <= '0;
        cnt_r    <= CW'(DIVIDEND_BITS);
      end else if (busy_r) begin
        num_r <= {num_r[DIVIDEND_BITS-2:0], 1'b0};
        if (!diff[DIVISOR_BITS+1]) begin
          rem_r    <= diff[DIVISOR_BITS:0];
          quotient <= {quotient[DIVIDEND_BITS-2:0], 1'b1};
        end else begin
          rem_r    <= trial[DIVISOR_BITS:0];
          quotient <= {quotient[DIVIDEND_BITS-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/mch_mul.sv =====
`default_nettype none
module mch_mul (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic signed [mch_pkg::DELTA_BITS-1:0] mult_a,
  input  wire logic [mch_pkg::SCALE_BITS-1:0]        mult_b,
  output logic                                       done,
  output logic signed [mch_pkg::PROD_BITS-1:0]       product
);
  import mch_pkg::*;

  localparam int CW = $clog2(SCALE_BITS + 1);

  logic signed [PROD_BITS-1:0] a_r;
  logic [SCALE_BITS-1:0]       b_r;
  logic [CW-1:0]               cnt_r;
  logic                        busy_r;

  // Shift and add, one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        a_r     <= PROD_BITS'(mult_a);
        b_r     <= mult_b;
        product <= '0;
        cnt_r   <= CW'(SCALE_BITS);
      end else if (busy_r) begin
        if (b_r[0]) begin
          product <= product + a_r;
        end
        a_r   <= a_r <<< 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/mch_cordic.sv =====
`default_nettype none
module mch_cordic #(
  parameter int CORDIC_ITERATIONS = mch_pkg::CORDIC_ITER_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    start,
  input  wire logic signed [mch_pkg::PROD_BITS-1:0]    vec_x,
  input  wire logic signed [mch_pkg::PROD_BITS-1:0]    vec_y,
  output logic                                         done,
  output logic signed [mch_pkg::HEADING_BITS-1:0]      heading
);
  import mch_pkg::*;

  localparam int NIT = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER : CORDIC_ITERATIONS;

  typedef enum logic [1:0] {C_IDLE, C_ITER, C_ROUND} cstate_t;

  cstate_t                      state_r;
  logic signed [VEC_BITS-1:0]   x_r, y_r;
  logic signed [ANGLE_BITS-1:0] z_r;
  logic [4:0]                   i_r;
  logic signed [VEC_BITS-1:0]   xw, yw, xs, ys;
  logic signed [ANGLE_BITS-1:0] zr;
  logic signed [ANGLE_BITS-FRAC_BITS-1:0] hr;

  assign xw = VEC_BITS'(vec_x);
  assign yw = VEC_BITS'(vec_y);
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  // Adding a half before the arithmetic shift rounds half up.
  assign zr = z_r + ANGLE_BITS'(1 <<< (FRAC_BITS - 1));
  assign hr = zr[ANGLE_BITS-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done    <= 1'b0;
      i_r     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            i_r <= '0;
            if (vec_x == '0 && vec_y == '0) begin
              heading <= '0;
              done    <= 1'b1;
            end else begin
              state_r <= C_ITER;
              if (vec_x < 0) begin
                if (vec_y >= 0) begin
                  x_r <= yw;
                  y_r <= -xw;
                  z_r <= QUARTER_TURN;
                end else begin
                  x_r <= -yw;
                  y_r <= xw;
                  z_r <= -QUARTER_TURN;
                end
              end else begin
                x_r <= xw;
                y_r <= yw;
                z_r <= '0;
              end
            end
          end
        end
        C_ITER: begin
          if (!y_r[VEC_BITS-1]) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_step(i_r);
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_step(i_r);
          end
          i_r <= i_r + 1'b1;
          if (i_r == 5'(NIT - 1)) begin
            state_r <= C_ROUND;
          end
        end
        C_ROUND: begin
          priority if (hr > (ANGLE_BITS-FRAC_BITS)'(HEADING_LIMIT)) begin
            heading <= HEADING_BITS'(HEADING_LIMIT);
          end else if (hr < -(ANGLE_BITS-FRAC_BITS)'(HEADING_LIMIT)) begin
            heading <= -HEADING_BITS'(HEADING_LIMIT);
          end else begin
            heading <= hr[HEADING_BITS-1:0];
          end
          done    <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/mch_checker.sv =====
`default_nettype none
module mch_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire mch_pkg::mch_out_t out_data
);
  import mch_pkg::*;

  // A result that is not taken stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.heading <= HEADING_BITS'(HEADING_LIMIT)) &&
                  (out_data.heading >= -HEADING_BITS'(HEADING_LIMIT)))
    else $error("heading out of range");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while one is in progress");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind magnetometer_calibrated_heading_top mch_checker u_mch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
